// ===== design/apd_pkg.sv =====
// ---------------------------------------------------------------------------
// apd_pkg: shared types and constants for the palette dither unit
// Geometry limits, register indexes and the front/back queue entry type.
// ---------------------------------------------------------------------------
package apd_pkg;

  localparam int MaxColumns = 1024;
  localparam int MaxColors  = 8;
  localparam int ColW       = $clog2(MaxColumns);
  localparam int RowW       = 13;
  localparam int AddrW      = $clog2(3 * MaxColumns);

  typedef enum logic [2:0] {
    REG_COLUMNS = 3'd0,
    REG_ROWS    = 3'd1,
    REG_COUNT   = 3'd2,
    REG_PAL01   = 3'd3,
    REG_PAL23   = 3'd4,
    REG_PAL45   = 3'd5,
    REG_PAL67   = 3'd6
  } reg_idx_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SRCH, S_ERR, S_RMW_RD, S_RMW_WR, S_EMIT
  } bstate_t;

  // One accepted item as the back end sees it
  typedef struct packed {
    logic            wr_pix;    // store the arriving pixel
    logic [AddrW-1:0] wr_addr;
    logic [23:0]     pix;
    logic            quant;     // quantize the pixel two rows back
    logic [ColW-1:0] col;
    logic [1:0]      ybank;     // (y % 3)
    logic            nb_c1;     // (c+1, y) inside
    logic            nb_c2;     // (c+2, y) inside
    logic            nb_dl;     // (c-1, y+1) inside
    logic            nb_d;      // (c, y+1) inside
    logic            nb_dr;     // (c+1, y+1) inside
    logic            nb_dd;     // (c, y+2) inside
    logic            last;
  } job_t;

  function automatic logic [1:0] bank_inc(input logic [1:0] b, input logic [1:0] k);
    logic [2:0] s;
    s = {1'b0, b} + {1'b0, k};
    bank_inc = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

endpackage

// ===== design/apd_front.sv =====
// ---------------------------------------------------------------------------
// apd_front: arrival tracking and item classification
// Counts columns and virtual rows, drops items of the wrong kind, and turns
// each accepted item into a job for the back end.
// ---------------------------------------------------------------------------
module apd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic [10:0]        image_columns,
  input  logic [11:0]        image_rows,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               item_func,
  input  logic [23:0]        item_pix,
  output logic               job_valid,
  input  logic               job_ready,
  output apd_pkg::job_t      job
);
  import apd_pkg::*;

  logic [ColW-1:0] col_r, col_nxt;
  logic [RowW-1:0] row_r, row_nxt;
  logic [1:0]      vbank_r, vbank_nxt;   // row_r % 3
  logic [11:0]     cols;
  logic [12:0]     rows;
  logic [ColW:0]   c1, c2;
  logic [RowW-1:0] y;
  logic            pix_phase, kind_ok, fire;
  logic [1:0]      ybank;

  always_comb begin
    if (image_columns == 11'd0) cols = 12'd1;
    else if (image_columns > 11'(MaxColumns)) cols = 12'(MaxColumns);
    else cols = {1'b0, image_columns};
    rows = (image_rows == 12'd0) ? 13'd1 : {1'b0, image_rows};
  end

  assign pix_phase  = (row_r < rows);
  assign kind_ok    = (item_func == !pix_phase);
  assign item_ready = job_ready || !kind_ok;
  assign fire       = item_valid && item_ready && kind_ok;
  assign y          = row_r - RowW'(2);
  assign ybank      = bank_inc(vbank_r, 2'd1);
  assign c1         = {1'b0, col_r} + 1'b1;
  assign c2         = {1'b0, col_r} + 2'd2;

  always_comb begin
    job.wr_pix  = pix_phase;
    job.wr_addr = AddrW'(vbank_r) * AddrW'(MaxColumns) + AddrW'(col_r);
    job.pix     = item_pix;
    job.quant   = (row_r >= RowW'(2));
    job.col     = col_r;
    job.ybank   = ybank;
    job.nb_c1   = (12'(c1) < cols);
    job.nb_c2   = (12'(c2) < cols);
    job.nb_d    = (y + RowW'(1) < rows);
    job.nb_dl   = job.nb_d && (col_r != '0);
    job.nb_dr   = job.nb_d && job.nb_c1;
    job.nb_dd   = (y + RowW'(2) < rows);
    job.last    = (y == rows - RowW'(1)) && (12'(c1) == cols);
  end
  assign job_valid = item_valid && kind_ok;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    vbank_nxt = vbank_r;
    if (fire) begin
      if (12'(c1) >= cols) begin
        col_nxt = '0;
        if (row_r + RowW'(1) >= rows + RowW'(2)) begin
          row_nxt   = '0;
          vbank_nxt = 2'd0;
        end else begin
          row_nxt   = row_r + RowW'(1);
          vbank_nxt = bank_inc(vbank_r, 2'd1);
        end
      end else begin
        col_nxt = c1[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r   <= '0;
      row_r   <= '0;
      vbank_r <= 2'd0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      vbank_r <= vbank_nxt;
    end
  end

endmodule

// ===== design/apd_queue.sv =====
// ---------------------------------------------------------------------------
// apd_queue: two-entry job queue between front and back end
// Lets the front accept while the back end is busy on a pixel.
// ---------------------------------------------------------------------------
module apd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  apd_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output apd_pkg::job_t out_job
);
  import apd_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_job   = mem_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/apd_back.sv =====
// ---------------------------------------------------------------------------
// apd_back: quantizer and error spreader
// Stores the arriving pixel, reads the pixel two rows back, finds the nearest
// palette color, then read-modify-writes up to six neighbors in the row store.
// ---------------------------------------------------------------------------
module apd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  apd_pkg::job_t job,
  input  logic [3:0]    palette_count,
  input  logic [191:0]  palette,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [2:0]    res_index,
  output logic          res_last
);
  import apd_pkg::*;

  logic [23:0]      store [3*MaxColumns];
  bstate_t          st_r, st_nxt;
  job_t             job_r;
  logic [23:0]      rd_r, p_r;
  logic [2:0]       ci_r, best_r, nb_r;
  logic [17:0]      bestd_r;
  logic [3:0]       ncol;
  logic [23:0]      pc;
  logic signed [8:0] er, eg, eb;
  logic [17:0]      sq_dist;
  logic signed [5:0] d_r [3];
  logic             we;
  logic [AddrW-1:0] waddr, raddr, nb_addr;
  logic [23:0]      wdata, sat;
  logic             nb_en;
  logic [1:0]       nb_bank;
  logic [ColW:0]    nb_col;
  logic             re;
  logic             res_v_r;
  logic [2:0]       res_i_r;
  logic             res_l_r;
  logic             d_latch_pending_r;
  logic             emit_go;

  always_comb begin
    if (palette_count == 4'd0) ncol = 4'd1;
    else if (palette_count > 4'(MaxColors)) ncol = 4'(MaxColors);
    else ncol = palette_count;
  end

  assign pc   = palette[24*ci_r +: 24];
  assign er   = $signed({1'b0, p_r[23:16]}) - $signed({1'b0, pc[23:16]});
  assign eg   = $signed({1'b0, p_r[15:8]}) - $signed({1'b0, pc[15:8]});
  assign eb   = $signed({1'b0, p_r[7:0]}) - $signed({1'b0, pc[7:0]});
  assign sq_dist = 18'(er * er) + 18'(eg * eg) + 18'(eb * eb);

  // neighbor sequence: right1, right2, downleft, down, downright, down2
  always_comb begin
    nb_en   = 1'b0;
    nb_bank = job_r.ybank;
    nb_col  = {1'b0, job_r.col};
    case (nb_r)
      3'd0: begin nb_en = job_r.nb_c1; nb_col = {1'b0, job_r.col} + 1'b1; end
      3'd1: begin nb_en = job_r.nb_c2; nb_col = {1'b0, job_r.col} + 2'd2; end
      3'd2: begin
        nb_en = job_r.nb_dl; nb_bank = bank_inc(job_r.ybank, 2'd1);
        nb_col = {1'b0, job_r.col} - 1'b1;
      end
      3'd3: begin nb_en = job_r.nb_d; nb_bank = bank_inc(job_r.ybank, 2'd1); end
      3'd4: begin
        nb_en = job_r.nb_dr; nb_bank = bank_inc(job_r.ybank, 2'd1);
        nb_col = {1'b0, job_r.col} + 1'b1;
      end
      3'd5: begin nb_en = job_r.nb_dd; nb_bank = bank_inc(job_r.ybank, 2'd2); end
      default: nb_en = 1'b0;
    endcase
    nb_addr = AddrW'(nb_bank) * AddrW'(MaxColumns) + AddrW'(nb_col[ColW-1:0]);
  end

  function automatic logic [7:0] sat_add(input logic [7:0] v, input logic signed [5:0] d);
    logic signed [9:0] s;
    s = $signed({2'b0, v}) + 10'(d);
    if (s < 0) sat_add = 8'd0;
    else if (s > 10'sd255) sat_add = 8'd255;
    else sat_add = s[7:0];
  endfunction

  assign sat = {sat_add(rd_r[23:16], d_r[0]), sat_add(rd_r[15:8], d_r[1]),
                sat_add(rd_r[7:0], d_r[2])};

  // keep working while a result waits; hold in S_EMIT until the slot frees
  assign job_ready = (st_r == S_IDLE);
  assign emit_go   = (st_r == S_EMIT) && (!res_v_r || res_ready);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:   if (job_valid && job_ready) st_nxt = job.quant ? S_RD : S_IDLE;
      S_RD:     st_nxt = S_SRCH;
      S_SRCH:   if (4'(ci_r) + 4'd1 >= ncol) st_nxt = S_ERR;
      S_ERR:    st_nxt = S_RMW_RD;
      S_RMW_RD: st_nxt = nb_en ? S_RMW_WR : ((nb_r == 3'd5) ? S_EMIT : S_RMW_RD);
      S_RMW_WR: st_nxt = (nb_r == 3'd5) ? S_EMIT : S_RMW_RD;
      S_EMIT:   st_nxt = emit_go ? S_IDLE : S_EMIT;
      default:  st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = job.wr_addr;
    wdata = job.pix;
    re    = 1'b0;
    raddr = AddrW'(job.ybank) * AddrW'(MaxColumns) + AddrW'(job.col);
    case (st_r)
      S_IDLE: begin
        we = job_valid && job_ready && job.wr_pix;
        re = job_valid && job_ready && job.quant;
      end
      S_RMW_RD: begin re = nb_en; raddr = nb_addr; end
      S_RMW_WR: begin we = 1'b1; waddr = nb_addr; wdata = sat; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) store[waddr] <= wdata;
    if (re) rd_r <= store[raddr];
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (job_valid && job_ready) job_r <= job;
      S_RD: begin
        p_r <= rd_r; ci_r <= 3'd0; best_r <= 3'd0; bestd_r <= 18'h3FFFF;
      end
      S_SRCH: begin
        if (sq_dist < bestd_r) begin bestd_r <= sq_dist; best_r <= ci_r; end
        ci_r <= ci_r + 3'd1;
      end
      S_ERR: begin
        ci_r <= best_r;
        nb_r <= 3'd0;
      end
      S_RMW_RD: if (!nb_en) nb_r <= nb_r + 3'd1;
      S_RMW_WR: nb_r <= nb_r + 3'd1;
      default: ;
    endcase
    // ci_r holds best during S_RMW_RD first cycle; er/eg/eb use it
    if (st_r == S_RMW_RD && nb_r == 3'd0 && d_latch_pending_r) begin
      d_r[0] <= 6'(er >>> 3);
      d_r[1] <= 6'(eg >>> 3);
      d_r[2] <= 6'(eb >>> 3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_latch_pending_r <= 1'b0;
    else d_latch_pending_r <= (st_r == S_ERR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      res_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit_go) begin
        res_v_r <= 1'b1;
        res_i_r <= best_r;
        res_l_r <= job_r.last;
      end else if (res_ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  assign res_valid = res_v_r;
  assign res_index = res_i_r;
  assign res_last  = res_l_r;

endmodule

// ===== design/atkinson_palette_dither_unit.sv =====
// ---------------------------------------------------------------------------
// atkinson_palette_dither_unit: Atkinson error-diffusion dither to a palette
// Streams RGB888 pixels in and palette indexes out, two rows behind.
// ---------------------------------------------------------------------------
// Usage: write geometry and palette over the cfg_ APB port while idle.
// Send pixels on in_ (tuser = 0) in raster order, then 2*columns flush
// words (tuser = 1). Each word from the third row on yields one out_ word
// with the palette index; out_tlast marks the last pixel of the frame.
// Words of the wrong kind are taken and dropped.
// A word that yields a result holds the back end through the color search
// over the palette and the read-modify-writes of up to six neighbors
// inside the image, done one after another on the row store; other words
// only store their pixel. A two-word queue lets the input accept while the
// back end works. When the receiver stalls, the result holds in the output
// register and the back end goes on with the next word, waiting only to
// hand over its own result.
// Reset: counters zero, 1024 columns, 480 rows, one color, colors zero.
// The row store is not cleared; it is always written before it is read.
// ---------------------------------------------------------------------------
module atkinson_palette_dither_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // color_index[2:0], zero fill
  output logic        out_tlast,  // frame_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import apd_pkg::*;

  logic [10:0]  cols_r;
  logic [11:0]  rows_r;
  logic [3:0]   count_r;
  logic [191:0] pal_r;
  logic         wr, restart;
  reg_idx_t     widx;
  logic         fq_valid, fq_ready, qb_valid, qb_ready;
  job_t         fjob, qjob;
  logic [2:0]   idx;

  assign cfg_pready = 1'b1;
  assign wr      = cfg_psel && cfg_penable && cfg_pwrite;
  assign widx    = reg_idx_t'(cfg_paddr[5:3]);
  assign restart = wr && (widx == REG_COLUMNS || widx == REG_ROWS) && cfg_paddr[2:0] == 3'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= 11'd1024;
      rows_r  <= 12'd480;
      count_r <= 4'd1;
      pal_r   <= '0;
    end else if (wr && cfg_paddr[2:0] == 3'd0) begin
      case (widx)
        REG_COLUMNS: cols_r <= cfg_pwdata[10:0];
        REG_ROWS:    rows_r <= cfg_pwdata[11:0];
        REG_COUNT:   count_r <= cfg_pwdata[3:0];
        REG_PAL01:   pal_r[47:0]    <= cfg_pwdata[47:0];
        REG_PAL23:   pal_r[95:48]   <= cfg_pwdata[47:0];
        REG_PAL45:   pal_r[143:96]  <= cfg_pwdata[47:0];
        REG_PAL67:   pal_r[191:144] <= cfg_pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_COLUMNS: cfg_prdata = 64'(cols_r);
      REG_ROWS:    cfg_prdata = 64'(rows_r);
      REG_COUNT:   cfg_prdata = 64'(count_r);
      REG_PAL01:   cfg_prdata = 64'(pal_r[47:0]);
      REG_PAL23:   cfg_prdata = 64'(pal_r[95:48]);
      REG_PAL45:   cfg_prdata = 64'(pal_r[143:96]);
      REG_PAL67:   cfg_prdata = 64'(pal_r[191:144]);
      default:     cfg_prdata = '0;
    endcase
  end

  apd_front u_front (
    .clk, .rst_n, .restart,
    .image_columns(cols_r), .image_rows(rows_r),
    .item_valid(in_tvalid), .item_ready(in_tready), .item_func(in_tuser),
    .item_pix({in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]}),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fjob)
  );

  apd_queue u_queue (
    .clk, .rst_n,
    .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fjob),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qjob)
  );

  apd_back u_back (
    .clk, .rst_n,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qjob),
    .palette_count(count_r), .palette(pal_r),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_index(idx), .res_last(out_tlast)
  );

  assign out_tdata = {5'd0, idx};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[2:0]} < count_r || count_r == 4'd0 ||
                    $past(count_r) != count_r || out_tdata[2:0] == 3'd0 || count_r > 4'd8))
    else $error("index beyond palette");

endmodule

// ===== verif/atkinson_palette_dither_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// atkinson_palette_dither_unit_test: self-checking bench for the dither unit
// Streams pixel and flush words through the unit under random handshake
// gaps, takes palette indexes from the directed rows or a behavioral model
// of the Atkinson diffusion kept in the bench, and compares them in order.
// ---------------------------------------------------------------------------
module atkinson_palette_dither_unit_test;
  import apd_pkg::*;

  localparam int DrainCycles = 64;
  localparam int CycleLimit  = 3000000;

  typedef struct {
    logic [2:0] idx;
    logic       done;
  } dither_res_t;

  typedef struct {
    logic       func;
    logic [7:0] r, g, b;
    bit         typed;
    logic [2:0] idx;
    logic       done;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [5:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  atkinson_palette_dither_unit DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bench copy of the unit's state and registers
  logic [23:0] px_store [3*MaxColumns];
  int unsigned at_col, at_row;
  logic [10:0] cols_reg;
  logic [11:0] rows_reg;
  logic [3:0]  count_reg;
  logic [47:0] pal_reg [4];

  dither_res_t pending_idx[$];
  int          err_count, useful_words, result_count, cycle_count, rdy_hold;
  bit          calm;

  task automatic report_miss(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_err(input int unsigned row, input int unsigned col, input int d[3]);
    int unsigned a;
    int s;
    a = (row % 3) * MaxColumns + col;
    for (int k = 0; k < 3; k++) begin
      s = int'(px_store[a][16-8*k +: 8]) + d[k];
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      px_store[a][16-8*k +: 8] = 8'(s);
    end
  endtask

  // Advance the model by one word; taken is low for a word of the wrong kind
  task automatic dither_step(input logic func, input logic [7:0] r, g, b,
                             output bit taken, output bit has, output dither_res_t res);
    int unsigned cols, rows, ncol, c, v, y, best, bestd, sq_dist;
    logic [23:0] p, q;
    int d[3];
    bit pix;
    cols = (cols_reg == 0) ? 1 : (cols_reg > MaxColumns) ? MaxColumns : cols_reg;
    rows = (rows_reg == 0) ? 1 : rows_reg;
    ncol = (count_reg == 0) ? 1 : (count_reg > MaxColors) ? MaxColors : count_reg;
    c = at_col;
    v = at_row;
    pix = v < rows;
    has = 0;
    res = '{idx: '0, done: 1'b0};
    if (c >= cols || v >= rows + 2) begin
      c = 0;
      v = 0;
      pix = 1;
    end
    taken = (func == !pix);
    if (!taken) return;
    if (pix) px_store[(v % 3) * MaxColumns + c] = {r, g, b};
    if (v >= 2) begin
      y = v - 2;
      p = px_store[(y % 3) * MaxColumns + c];
      best = 0;
      bestd = 255 * 255 * 3 + 1;
      for (int i = 0; i < ncol; i++) begin
        q = pal_reg[i >> 1][(i & 1) * 24 +: 24];
        sq_dist = 0;
        for (int k = 0; k < 3; k++)
          sq_dist += (int'(p[8*k +: 8]) - int'(q[8*k +: 8])) ** 2;
        if (sq_dist < bestd) begin
          bestd = sq_dist;
          best = i;
        end
      end
      q = pal_reg[best >> 1][(best & 1) * 24 +: 24];
      for (int k = 0; k < 3; k++)
        d[k] = (int'(p[16-8*k +: 8]) - int'(q[16-8*k +: 8])) >>> 3;
      if (c + 1 < cols) add_err(y, c + 1, d);
      if (c + 2 < cols) add_err(y, c + 2, d);
      if (y + 1 < rows) begin
        if (c >= 1) add_err(y + 1, c - 1, d);
        add_err(y + 1, c, d);
        if (c + 1 < cols) add_err(y + 1, c + 1, d);
      end
      if (y + 2 < rows) add_err(y + 2, c, d);
      has = 1;
      res.idx = 3'(best);
      res.done = (y == rows - 1 && c == cols - 1);
    end
    c++;
    if (c >= cols) begin
      c = 0;
      v++;
      if (v >= rows + 2) v = 0;
    end
    at_col = c;
    at_row = v;
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 6'(8 * idx);
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_COLUMNS: begin
        cols_reg = val[10:0];
        at_col = 0;
        at_row = 0;
      end
      REG_ROWS: begin
        rows_reg = val[11:0];
        at_col = 0;
        at_row = 0;
      end
      REG_COUNT: count_reg = val[3:0];
      default: pal_reg[idx - REG_PAL01] = val[47:0];
    endcase
  endtask

  // Hold the sender until every result is in, then let the back end settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_idx.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_word(input logic func, input logic [7:0] r, g, b,
                           input bit typed = 0, input logic [2:0] tidx = '0,
                           input logic tdone = 1'b0);
    int gap;
    bit taken, has;
    dither_res_t res;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    dither_step(func, r, g, b, taken, has, res);
    if (taken) useful_words++;
    if (has) pending_idx.push_back(typed ? dither_res_t'{idx: tidx, done: tdone} : res);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rnd_chan();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [47:0] rnd_pal();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {16'($urandom), $urandom};
    endcase
  endfunction

  task automatic send_pixel();
    if ($urandom_range(0, 15) == 0) send_word(1'b1, rnd_chan(), rnd_chan(), rnd_chan());
    send_word(1'b0, rnd_chan(), rnd_chan(), rnd_chan());
  endtask

  task automatic send_flush();
    if ($urandom_range(0, 15) == 0) send_word(1'b0, rnd_chan(), rnd_chan(), rnd_chan());
    send_word(1'b1, rnd_chan(), rnd_chan(), rnd_chan());
  endtask

  // Receiver: stall a random number of cycles before each word
  always @(negedge clk) begin
    if (rdy_hold > 0) begin
      out_tready <= 1'b0;
      rdy_hold <= rdy_hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      rdy_hold <= calm ? 0 : $urandom_range(0, 17);
      result_count++;
      if (pending_idx.size() == 0) begin
        report_miss($sformatf("unexpected word idx=%0d last=%0b", out_tdata[2:0], out_tlast));
      end else begin
        if (out_tdata[2:0] !== pending_idx[0].idx)
          report_miss($sformatf("color_index %0d, want %0d", out_tdata[2:0],
                                pending_idx[0].idx));
        if (out_tlast !== pending_idx[0].done)
          report_miss($sformatf("frame_done %0b, want %0b", out_tlast, pending_idx[0].done));
        void'(pending_idx.pop_front());
      end
    end
  end

  dir_row_t dir_rows[] = '{
    '{1'b1, 8'h12, 8'h34, 8'h56, 0, 3'd0, 1'b0},  // flush during pixel rows: drop
    '{1'b0, 8'h00, 8'h00, 8'h00, 0, 3'd0, 1'b0},
    '{1'b0, 8'hff, 8'hff, 8'hff, 0, 3'd0, 1'b0},
    '{1'b0, 8'hff, 8'h00, 8'h00, 0, 3'd0, 1'b0},
    '{1'b0, 8'h00, 8'hff, 8'h00, 0, 3'd0, 1'b0},
    '{1'b0, 8'h00, 8'h00, 8'hff, 0, 3'd0, 1'b0},
    '{1'b0, 8'h80, 8'h80, 8'h80, 0, 3'd0, 1'b0},
    '{1'b0, 8'haa, 8'h55, 8'h0f, 0, 3'd0, 1'b0},  // pixel during flush rows: drop
    '{1'b1, 8'h00, 8'h00, 8'h00, 1, 3'd0, 1'b0},
    '{1'b1, 8'hff, 8'hff, 8'hff, 1, 3'd1, 1'b0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 1, 3'd2, 1'b0},
    '{1'b1, 8'hff, 8'hff, 8'hff, 1, 3'd3, 1'b0},  // green twice: lower index wins
    '{1'b1, 8'h00, 8'h00, 8'h00, 1, 3'd4, 1'b0},
    '{1'b1, 8'hff, 8'hff, 8'hff, 1, 3'd6, 1'b1},  // gray twice: lower index wins
    '{1'b0, 8'h7f, 8'h01, 8'hfe, 0, 3'd0, 1'b0},
    '{1'b0, 8'h01, 8'hfe, 8'h7f, 0, 3'd0, 1'b0},
    '{1'b0, 8'hfe, 8'h7f, 8'h01, 0, 3'd0, 1'b0},
    '{1'b0, 8'h10, 8'hf0, 8'h33, 0, 3'd0, 1'b0},
    '{1'b0, 8'hc8, 8'h64, 8'h20, 0, 3'd0, 1'b0},
    '{1'b0, 8'h05, 8'h09, 8'hf7, 0, 3'd0, 1'b0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 0, 3'd0, 1'b0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 0, 3'd0, 1'b0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 0, 3'd0, 1'b0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 0, 3'd0, 1'b0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 0, 3'd0, 1'b0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 0, 3'd0, 1'b0}
  };

  initial begin
    int cols, rows, frames;
    bit broke;
    cols_reg = 11'd1024;
    rows_reg = 12'd480;
    count_reg = 4'd1;
    for (int i = 0; i < 4; i++) pal_reg[i] = '0;
    for (int i = 0; i < 3 * MaxColumns; i++) px_store[i] = '0;
    at_col = 0;
    at_row = 0;
    rdy_hold = 0;
    calm = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: 3x2 frame, exact palette hits, ties and wrong-kind words
    cfg_write(REG_COLUMNS, 64'd3);
    cfg_write(REG_ROWS, 64'd2);
    cfg_write(REG_COUNT, 64'd8);
    cfg_write(REG_PAL01, {24'hffffff, 24'h000000});
    cfg_write(REG_PAL23, {24'h00ff00, 24'hff0000});
    cfg_write(REG_PAL45, {24'h00ff00, 24'h0000ff});
    cfg_write(REG_PAL67, {24'h808080, 24'h808080});
    foreach (dir_rows[i])
      send_word(dir_rows[i].func, dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
                dir_rows[i].typed, dir_rows[i].idx, dir_rows[i].done);
    drain();

    // Tall single column, cut short and restarted by the next geometry write
    cfg_write(REG_ROWS, 64'd4095);
    cfg_write(REG_COLUMNS, 64'd1);
    cfg_write(REG_COUNT, 64'd15);
    for (int i = 0; i < 20; i++) begin
      send_word(1'b0, rnd_chan(), rnd_chan(), rnd_chan());
      if (i == 10) drain();
    end
    drain();

    // Random frames, mostly well formed
    useful_words = 0;
    frames = 0;
    while (useful_words < 550) begin
      calm = ($urandom_range(0, 3) == 0);
      cols = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
      rows = $urandom_range(0, 5);
      cfg_write(REG_COLUMNS, 64'(cols));
      cfg_write(REG_ROWS, 64'(rows));
      if (frames == 0 || $urandom_range(0, 1)) begin
        cfg_write(REG_COUNT, 64'($urandom_range(0, 15)));
        cfg_write(REG_PAL01, rnd_pal());
        cfg_write(REG_PAL23, rnd_pal());
        cfg_write(REG_PAL45, rnd_pal());
        cfg_write(REG_PAL67, rnd_pal());
      end
      if (cols == 0) cols = 1;
      if (rows == 0) rows = 1;
      broke = 0;
      for (int i = 0; i < cols * rows && !broke; i++) begin
        send_pixel();
        if ($urandom_range(0, 63) == 0) begin
          drain();
          // change the palette mid-frame or abandon the frame
          if ($urandom_range(0, 1)) cfg_write(reg_idx_t'($urandom_range(2, 6)), rnd_pal());
          else broke = 1;
        end
      end
      if (!broke) for (int i = 0; i < 2 * cols; i++) send_flush();
      drain();
      frames++;
    end

    calm = 1;
    drain();
    foreach (pending_idx[i])
      report_miss($sformatf("missing word idx=%0d", pending_idx[i].idx));
    $display("covered %0d random frames and a tall single-column frame, %0d results checked",
             frames, result_count);
    $display("wrong-kind words, zero geometry and palette counts, ties and palette changes");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
